// ===== sv/tesf_pkg.sv =====
// Shared types, character constants and result sequencing for the terminal escape filter.
// No dependencies; every other file imports this package.
package tesf_pkg;

  localparam int unsigned TESF_QUEUE_DEPTH = 2;
  localparam int unsigned STEP_W           = 3;
  localparam int unsigned CFG_INDEX_W      = 3;
  localparam int unsigned CFG_DATA_W       = 8;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [6:0] CH_SPACE = 7'h20;

  typedef enum logic [2:0] {
    REG_ESCAPE_CHAR  = 3'd0,
    REG_ESCAPE_EN    = 3'd1,
    REG_EOF_CHAR     = 3'd2,
    REG_INTR_CHAR    = 3'd3,
    REG_KILL_CHAR    = 3'd4,
    REG_SUSP_CHAR    = 3'd5,
    REG_DSUSP_CHAR   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_TERM  = 2'd1,
    ACT_SUSP  = 2'd2,
    ACT_DSUSP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_FWD     = 2'd0,
    CMD_FWD_ESC = 2'd1,
    CMD_ECHO    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] key;
    logic [7:0] esc;
    action_t    act;
  } cmd_t;

  typedef struct packed {
    logic       to_local;
    logic [7:0] data;
    action_t    act;
    logic       last;
  } res_t;

  // Result number step of the burst that one command expands into.
  function automatic res_t res_at(cmd_t cmd, logic [STEP_W-1:0] step);
    res_t       r;
    logic [6:0] c7;
    logic       caret;
    c7    = cmd.key[6:0];
    caret = (c7 < CH_SPACE) || (c7 == CH_DEL);
    r     = '{to_local: 1'b0, data: cmd.key, act: ACT_NONE, last: 1'b0};
    case (cmd.kind)
      CMD_FWD: begin
        r.last = 1'b1;
      end
      CMD_FWD_ESC: begin
        if (step == '0) begin
          r.data = cmd.esc;
        end else begin
          r.last = 1'b1;
        end
      end
      CMD_ECHO: begin
        r.to_local = 1'b1;
        case (step)
          3'd0: r.data = cmd.esc;
          3'd1: r.data = caret ? CH_CARET : {1'b0, c7};
          3'd2: begin
            if (!caret) begin
              r.data = CH_CR;
            end else if (c7 == CH_DEL) begin
              r.data = CH_QMARK;
            end else begin
              r.data = {1'b0, c7} + CH_AT;
            end
          end
          3'd3: begin
            if (caret) begin
              r.data = CH_CR;
            end else begin
              r.data = CH_LF;
              r.last = 1'b1;
            end
          end
          default: begin
            r.data = CH_LF;
            r.last = 1'b1;
          end
        endcase
        if (r.last) begin
          r.act = cmd.act;
        end
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tesf_front.sv =====
// Front end: configuration registers, line-start and escape tracking, command classification.
// Depends on tesf_pkg; pushes one command per accepted byte that causes results.
module tesf_front import tesf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   accept,
  input  logic [7:0]             key_byte,
  output logic                   push,
  output cmd_t                   cmd
);

  logic [7:0] esc_r, eof_r, intr_r, kill_r, susp_r, dsusp_r;
  logic       esc_en_r;
  logic       line_start_r, line_start_nxt;
  logic       pending_r, pending_nxt;
  logic       halted_r, halted_nxt;
  logic       ends_line;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 8'd126;
      esc_en_r <= 1'b1;
      eof_r    <= 8'd4;
      intr_r   <= 8'd3;
      kill_r   <= 8'd21;
      susp_r   <= 8'd26;
      dsusp_r  <= 8'd25;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ESCAPE_CHAR: esc_r    <= cfg_wdata;
        REG_ESCAPE_EN:   esc_en_r <= cfg_wdata[0];
        REG_EOF_CHAR:    eof_r    <= cfg_wdata;
        REG_INTR_CHAR:   intr_r   <= cfg_wdata;
        REG_KILL_CHAR:   kill_r   <= cfg_wdata;
        REG_SUSP_CHAR:   susp_r   <= cfg_wdata;
        REG_DSUSP_CHAR:  dsusp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ends_line = (key_byte == kill_r) || (key_byte == eof_r) || (key_byte == intr_r) ||
                     (key_byte == susp_r) || (key_byte == CH_CR) || (key_byte == CH_LF);

  always_comb begin
    line_start_nxt = line_start_r;
    pending_nxt    = pending_r;
    halted_nxt     = halted_r;
    push           = 1'b0;
    cmd            = '{kind: CMD_FWD, key: key_byte, esc: esc_r, act: ACT_NONE};
    if (accept && !halted_r) begin
      push           = 1'b1;
      line_start_nxt = ends_line;
      if (line_start_r) begin
        if (esc_en_r && key_byte == esc_r) begin
          line_start_nxt = 1'b0;
          pending_nxt    = 1'b1;
          push           = 1'b0;
        end
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        if (key_byte == CH_DOT || key_byte == eof_r) begin
          cmd.kind   = CMD_ECHO;
          cmd.act    = ACT_TERM;
          halted_nxt = 1'b1;
        end else if (key_byte == susp_r || key_byte == dsusp_r) begin
          cmd.kind       = CMD_ECHO;
          cmd.act        = (key_byte == susp_r) ? ACT_SUSP : ACT_DSUSP;
          line_start_nxt = 1'b1;
        end else if (key_byte != esc_r) begin
          cmd.kind = CMD_FWD_ESC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= 1'b1;
      pending_r    <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      line_start_r <= line_start_nxt;
      pending_r    <= pending_nxt;
      halted_r     <= halted_nxt;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !push) else $error("command pushed after terminate");

  a_pending_not_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> !line_start_r) else $error("escape pending at line start");

endmodule

// ===== sv/tesf_queue.sv =====
// Short command queue between front and back end, held in flip-flops.
// Depends on tesf_pkg for the command type.
module tesf_queue import tesf_pkg::*; #(
  parameter int unsigned DEPTH = TESF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count beyond depth");

endmodule

// ===== sv/tesf_back.sv =====
// Back end: expands the queue head into its result burst, one result per cycle
// while the output register is free, into that register. Depends on tesf_pkg.
module tesf_back import tesf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t head,
  input  logic q_empty,
  output logic q_pop,
  input  logic out_pop,
  output logic out_empty,
  output res_t out_res
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;
  res_t              cur;
  logic              load;

  assign cur  = res_at(head, step_r);
  assign load = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = load && cur.last;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = cur.last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_res   = out_r;

  a_burst_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> !q_empty) else $error("burst in progress with empty queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue popped while empty");

endmodule

// ===== sv/terminal_escape_sequence_filter.sv =====
// Terminal escape filter, top level: connects front end, command queue and back end.
// Depends on tesf_pkg, tesf_front, tesf_queue and tesf_back.
// A keyboard byte is accepted every cycle while full is low; a byte yields one to five
// result items, and the back end delivers one result item per cycle while its output
// register is empty or popped, so plain forwarded bytes stream at one item per cycle,
// while a byte with two results or a local command echo holds the back end per result.
// A byte is classified and written into the queue at the accepting edge, and the
// output register takes its first result from the queue head once it is free. A held
// escape byte and every byte after a terminate give no result.
module terminal_escape_sequence_filter import tesf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = TESF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_key_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic                   out_to_local,
  output logic [7:0]             out_out_byte,
  output logic [1:0]             out_action,
  output logic                   out_last
);

  logic accept;
  logic q_push, q_pop, q_empty, q_full;
  cmd_t front_cmd, head;
  res_t res;

  assign full   = q_full;
  assign accept = push && !q_full;

  tesf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .key_byte  (in_key_byte),
    .push      (q_push),
    .cmd       (front_cmd)
  );

  tesf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tesf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_res   (res)
  );

  assign out_to_local = res.to_local;
  assign out_out_byte = res.data;
  assign out_action   = 2'(res.act);
  assign out_last     = res.last;

endmodule
